// ===== rtl/core/qvc_pkg.sv =====
package qvc_pkg;

  localparam int COORD_WIDTH  = 20;
  localparam int CORNER_COUNT = 4;
  localparam int FRAC_BITS    = 4;
  localparam int ONE_TEXEL_SQ = 1 << (2 * FRAC_BITS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SQ_W       = 2 * CFG_DATA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CORNER_SINE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STEEP_EDGE_RATIO = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] MIN_CORNER_SINE_RST  = CFG_DATA_W'(3277);
  localparam logic [CFG_DATA_W-1:0] STEEP_EDGE_RATIO_RST = CFG_DATA_W'(768);

  localparam int EXTENT_W = 17;
  localparam logic [EXTENT_W-1:0] EXTENT_MAX = '1;
  localparam longint EXT_LIM = ((longint'(EXTENT_MAX) + 1) << FRAC_BITS) - 8;
  localparam logic [63:0] EXT_LIM_SQ = 64'(EXT_LIM * EXT_LIM);

  localparam int MUL_CHUNK = 24;
  localparam int MUL_LAT   = 2;

  localparam int SQRT_BITS      = 22;
  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STEPS     = SQRT_BITS / SQRT_PER_STAGE;
  localparam int SQRT_REM_W     = 2 * SQRT_BITS;
  localparam int SQRT_LAT       = SQRT_STEPS + 1;

  typedef enum logic [2:0] {
    VERDICT_USABLE,
    VERDICT_COLLAPSED,
    VERDICT_COLLINEAR,
    VERDICT_CROSSING,
    VERDICT_MIRRORED
  } verdict_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] top_left_x;
    logic signed [COORD_WIDTH-1:0] top_left_y;
    logic signed [COORD_WIDTH-1:0] top_right_x;
    logic signed [COORD_WIDTH-1:0] top_right_y;
    logic signed [COORD_WIDTH-1:0] bottom_right_x;
    logic signed [COORD_WIDTH-1:0] bottom_right_y;
    logic signed [COORD_WIDTH-1:0] bottom_left_x;
    logic signed [COORD_WIDTH-1:0] bottom_left_y;
  } quad_in_t;

  typedef struct packed {
    verdict_e              verdict;
    logic [EXTENT_W-1:0]   extent_width;
    logic [EXTENT_W-1:0]   extent_height;
    logic                  steep;
  } quad_out_t;

endpackage

// ===== rtl/core/qvc_mul.sv =====
module qvc_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);
  import qvc_pkg::*;

  localparam int CH = MUL_CHUNK;
  localparam int NA = (AW + CH - 1) / CH;
  localparam int NB = (BW + CH - 1) / CH;
  localparam int PW = AW + BW;

  logic [NA*CH-1:0] a_ext;
  logic [NB*CH-1:0] b_ext;
  logic [2*CH-1:0]  pp_q [NA][NB];
  logic [PW-1:0]    sum_d;

  always_comb begin
    a_ext = '0;
    b_ext = '0;
    a_ext[AW-1:0] = a_i;
    b_ext[BW-1:0] = b_i;
  end

  // partial products, one chunk pair each
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_ext[i*CH +: CH] * b_ext[j*CH +: CH];
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_d = sum_d + (PW'(pp_q[i][j]) << ((i + j) * CH));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= sum_d;
    end
  end

endmodule

// ===== rtl/core/qvc_sqrt.sv =====
module qvc_sqrt #(
  parameter int DW = 41
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [DW-1:0]                d_i,
  output logic [qvc_pkg::EXTENT_W-1:0] ext_o
);
  import qvc_pkg::*;

  localparam int RB = SQRT_BITS;
  localparam int RW = SQRT_REM_W;
  localparam int NS = SQRT_STEPS;
  localparam int PS = SQRT_PER_STAGE;
  localparam int CW = (DW > 64) ? DW : 64;

  logic          sat_d;
  logic          sat_q  [NS];
  logic [RW-1:0] rem_q  [NS];
  logic [RB-1:0] root_q [NS];
  logic [RW-1:0] rem_d  [NS];
  logic [RB-1:0] root_d [NS];
  logic [RB:0]   rnd_d;
  logic [RB:0]   n_d;
  logic [EXTENT_W-1:0] ext_d;

  assign sat_d = CW'(d_i) >= CW'(EXT_LIM_SQ);

  // restoring square root, two result bits per stage
  always_comb begin
    logic [RW-1:0] r;
    logic [RB-1:0] o;
    logic [RW-1:0] tr;
    int            b;
    for (int k = 0; k < NS; k++) begin
      r = rem_q[k];
      o = root_q[k];
      for (int j = 0; j < PS; j++) begin
        b  = RB - 1 - k * PS - j;
        tr = (RW'(o) << (b + 1)) + (RW'(1) << (2 * b));
        if (r >= tr) begin
          r = r - tr;
          o = o | (RB'(1) << b);
        end
      end
      rem_d[k]  = r;
      root_d[k] = o;
    end
  end

  // round half up to whole texels, floor of one, saturate
  always_comb begin
    rnd_d = (RB + 1)'(root_d[NS-1]) + (RB + 1)'(1 << (FRAC_BITS - 1));
    n_d   = rnd_d >> FRAC_BITS;
    if (sat_q[NS-1] || n_d > (RB + 1)'(EXTENT_MAX)) begin
      ext_d = EXTENT_MAX;
    end else if (n_d == '0) begin
      ext_d = EXTENT_W'(1);
    end else begin
      ext_d = n_d[EXTENT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0]  <= sat_d;
      rem_q[0]  <= sat_d ? '0 : RW'(d_i);
      root_q[0] <= '0;
      for (int k = 0; k < NS - 1; k++) begin
        sat_q[k+1]  <= sat_q[k];
        rem_q[k+1]  <= rem_d[k];
        root_q[k+1] <= root_d[k];
      end
      ext_o <= ext_d;
    end
  end

endmodule

// ===== rtl/core/quad_validity_classifier_top.sv =====
// Throughput: one quad per cycle; the whole pipeline holds while the
// output register is full and out_ready_i is low.
// The depth is set by the extent square root, two bits per stage.
// Reset clears all pipeline valid bits and loads the register defaults.
module quad_validity_classifier_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  qvc_pkg::quad_in_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output qvc_pkg::quad_out_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [qvc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [qvc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import qvc_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int DW    = W + 1;
  localparam int SW    = 2 * W;
  localparam int D2W   = 2 * W + 1;
  localparam int TW    = 2 * DW;
  localparam int TAW   = TW - 1;
  localparam int TSQW  = 2 * TAW;
  localparam int EEW   = 2 * D2W;
  localparam int RHSW  = SQ_W + EEW;
  localparam int CMPW  = TSQW + SQ_W;
  localparam int SHW   = SQ_W + D2W;
  localparam int NCOR  = CORNER_COUNT;
  localparam int NPAIR = NCOR + 2;
  localparam int NST   = 4 + SQRT_LAT;
  localparam int VDEL  = SQRT_LAT - 2 * MUL_LAT;

  typedef struct packed {
    verdict_e verdict;
    logic     steep;
  } res_t;

  logic           ce;
  logic [NST-1:0] vld_q;

  logic [SQ_W-1:0] sine_sq_q, ratio_sq_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sine_sq_q  <= SQ_W'(MIN_CORNER_SINE_RST) * SQ_W'(MIN_CORNER_SINE_RST);
      ratio_sq_q <= SQ_W'(STEEP_EDGE_RATIO_RST) * SQ_W'(STEEP_EDGE_RATIO_RST);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_CORNER_SINE:  sine_sq_q  <= SQ_W'(cfg_data_i) * SQ_W'(cfg_data_i);
        CFG_STEEP_EDGE_RATIO: ratio_sq_q <= SQ_W'(cfg_data_i) * SQ_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign ce          = ~vld_q[NST-1] | out_ready_i;
  assign in_ready_o  = ce;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // stage 1: edge and diagonal differences
  logic signed [W-1:0]  cx [NCOR];
  logic signed [W-1:0]  cy [NCOR];
  logic signed [DW-1:0] dx_d [NPAIR];
  logic signed [DW-1:0] dy_d [NPAIR];
  logic signed [DW-1:0] dx_q [NPAIR];
  logic signed [DW-1:0] dy_q [NPAIR];

  assign cx[0] = in_item_i.top_left_x;
  assign cy[0] = in_item_i.top_left_y;
  assign cx[1] = in_item_i.top_right_x;
  assign cy[1] = in_item_i.top_right_y;
  assign cx[2] = in_item_i.bottom_right_x;
  assign cy[2] = in_item_i.bottom_right_y;
  assign cx[3] = in_item_i.bottom_left_x;
  assign cy[3] = in_item_i.bottom_left_y;

  always_comb begin
    for (int i = 0; i < NCOR; i++) begin
      dx_d[i] = DW'(cx[(i == NCOR - 1) ? 0 : i + 1]) - DW'(cx[i]);
      dy_d[i] = DW'(cy[(i == NCOR - 1) ? 0 : i + 1]) - DW'(cy[i]);
    end
    dx_d[NCOR]     = DW'(cx[2]) - DW'(cx[0]);
    dy_d[NCOR]     = DW'(cy[2]) - DW'(cy[0]);
    dx_d[NCOR + 1] = DW'(cx[3]) - DW'(cx[1]);
    dy_d[NCOR + 1] = DW'(cy[3]) - DW'(cy[1]);
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // stage 2: squares and cross products
  logic signed [TW-1:0] sxx_d [NPAIR];
  logic signed [TW-1:0] syy_d [NPAIR];
  logic signed [TW-1:0] cp_d  [NCOR];
  logic signed [TW-1:0] cq_d  [NCOR];
  logic [SW-1:0]        sqx_q [NPAIR];
  logic [SW-1:0]        sqy_q [NPAIR];
  logic signed [TW-1:0] cp_q  [NCOR];
  logic signed [TW-1:0] cq_q  [NCOR];

  always_comb begin
    for (int k = 0; k < NPAIR; k++) begin
      sxx_d[k] = dx_q[k] * dx_q[k];
      syy_d[k] = dy_q[k] * dy_q[k];
    end
    for (int i = 0; i < NCOR; i++) begin
      cp_d[i] = dx_q[i] * dy_q[(i == NCOR - 1) ? 0 : i + 1];
      cq_d[i] = dy_q[i] * dx_q[(i == NCOR - 1) ? 0 : i + 1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int k = 0; k < NPAIR; k++) begin
        sqx_q[k] <= sxx_d[k][SW-1:0];
        sqy_q[k] <= syy_d[k][SW-1:0];
      end
      cp_q <= cp_d;
      cq_q <= cq_d;
    end
  end

  // stage 3: squared distances and turns
  logic [D2W-1:0]       d2_q [NPAIR];
  logic signed [TW-1:0] t_q  [NCOR];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int k = 0; k < NPAIR; k++) begin
        d2_q[k] <= D2W'(sqx_q[k]) + D2W'(sqy_q[k]);
      end
      for (int i = 0; i < NCOR; i++) begin
        t_q[i] <= cp_q[i] - cq_q[i];
      end
    end
  end

  // stage 4: collapse test, turn magnitude and sign, edge ordering
  logic                 coll_d;
  logic [TW-1:0]        tneg_d [NCOR];
  logic                 coll4_q;
  logic [TAW-1:0]       tabs4_q [NCOR];
  logic [NCOR-1:0]      tpos4_q;
  logic [D2W-1:0]       e2_4_q [NCOR];
  logic [D2W-1:0]       hmax4_q, hmin4_q, vmax4_q, vmin4_q;

  always_comb begin
    coll_d = 1'b0;
    for (int k = 0; k < NPAIR; k++) begin
      if (d2_q[k] < D2W'(ONE_TEXEL_SQ)) begin
        coll_d = 1'b1;
      end
    end
    for (int i = 0; i < NCOR; i++) begin
      tneg_d[i] = -t_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      coll4_q <= coll_d;
      for (int i = 0; i < NCOR; i++) begin
        tabs4_q[i] <= t_q[i][TW-1] ? tneg_d[i][TAW-1:0] : t_q[i][TAW-1:0];
        tpos4_q[i] <= !t_q[i][TW-1] && (t_q[i] != '0);
        e2_4_q[i]  <= d2_q[i];
      end
      // top is edge 0, right 1, bottom 2, left 3
      hmax4_q <= (d2_q[0] >= d2_q[2]) ? d2_q[0] : d2_q[2];
      hmin4_q <= (d2_q[0] >= d2_q[2]) ? d2_q[2] : d2_q[0];
      vmax4_q <= (d2_q[3] >= d2_q[1]) ? d2_q[3] : d2_q[1];
      vmin4_q <= (d2_q[3] >= d2_q[1]) ? d2_q[1] : d2_q[3];
    end
  end

  // stages 5-6: turn squares, edge products, steep products
  logic [TSQW-1:0] tsq6 [NCOR];
  logic [EEW-1:0]  ee6  [NCOR];
  logic [SHW-1:0]  sh6, sv6;

  for (genvar g = 0; g < NCOR; g++) begin : g_turn
    qvc_mul #(.AW(TAW), .BW(TAW)) u_tsq (
      .clk_i (clk_i),
      .en_i  (ce),
      .a_i   (tabs4_q[g]),
      .b_i   (tabs4_q[g]),
      .p_o   (tsq6[g])
    );
    qvc_mul #(.AW(D2W), .BW(D2W)) u_ee (
      .clk_i (clk_i),
      .en_i  (ce),
      .a_i   (e2_4_q[g]),
      .b_i   (e2_4_q[(g == NCOR - 1) ? 0 : g + 1]),
      .p_o   (ee6[g])
    );
  end

  qvc_mul #(.AW(SQ_W), .BW(D2W)) u_sh (
    .clk_i (clk_i),
    .en_i  (ce),
    .a_i   (ratio_sq_q),
    .b_i   (hmin4_q),
    .p_o   (sh6)
  );

  qvc_mul #(.AW(SQ_W), .BW(D2W)) u_sv (
    .clk_i (clk_i),
    .en_i  (ce),
    .a_i   (ratio_sq_q),
    .b_i   (vmin4_q),
    .p_o   (sv6)
  );

  logic            coll5_q, coll6_q, coll7_q, coll8_q;
  logic [NCOR-1:0] tpos5_q, tpos6_q, tpos7_q, tpos8_q;
  logic [D2W-1:0]  hmax5_q, hmax6_q, vmax5_q, vmax6_q;
  logic            steep_d, steep7_q, steep8_q;
  logic [TSQW-1:0] tsq7_q [NCOR];
  logic [TSQW-1:0] tsq8_q [NCOR];

  assign steep_d = (SHW'({hmax6_q, 16'h0}) > sh6) || (SHW'({vmax6_q, 16'h0}) > sv6);

  always_ff @(posedge clk_i) begin
    if (ce) begin
      coll5_q  <= coll4_q;
      coll6_q  <= coll5_q;
      coll7_q  <= coll6_q;
      coll8_q  <= coll7_q;
      tpos5_q  <= tpos4_q;
      tpos6_q  <= tpos5_q;
      tpos7_q  <= tpos6_q;
      tpos8_q  <= tpos7_q;
      hmax5_q  <= hmax4_q;
      hmax6_q  <= hmax5_q;
      vmax5_q  <= vmax4_q;
      vmax6_q  <= vmax5_q;
      steep7_q <= steep_d;
      steep8_q <= steep7_q;
      tsq7_q   <= tsq6;
      tsq8_q   <= tsq7_q;
    end
  end

  // stages 7-8: sine threshold times edge products
  logic [RHSW-1:0] rhs8 [NCOR];

  for (genvar g = 0; g < NCOR; g++) begin : g_rhs
    qvc_mul #(.AW(SQ_W), .BW(EEW)) u_rhs (
      .clk_i (clk_i),
      .en_i  (ce),
      .a_i   (sine_sq_q),
      .b_i   (ee6[g]),
      .p_o   (rhs8[g])
    );
  end

  logic lin_d;
  res_t res_d;
  res_t vd_q [VDEL];

  always_comb begin
    lin_d = 1'b0;
    for (int i = 0; i < NCOR; i++) begin
      if (CMPW'({tsq8_q[i], {SQ_W{1'b0}}}) < CMPW'(rhs8[i])) begin
        lin_d = 1'b1;
      end
    end
    if (coll8_q) begin
      res_d.verdict = VERDICT_COLLAPSED;
    end else if (lin_d) begin
      res_d.verdict = VERDICT_COLLINEAR;
    end else if (tpos8_q == '0) begin
      res_d.verdict = VERDICT_MIRRORED;
    end else if (tpos8_q != '1) begin
      res_d.verdict = VERDICT_CROSSING;
    end else begin
      res_d.verdict = VERDICT_USABLE;
    end
    res_d.steep = (res_d.verdict == VERDICT_USABLE) && steep8_q;
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      vd_q[0] <= res_d;
      for (int k = 1; k < VDEL; k++) begin
        vd_q[k] <= vd_q[k-1];
      end
    end
  end

  // extents, aligned with the verdict delay line
  logic [EXTENT_W-1:0] ext_w, ext_h;

  qvc_sqrt #(.DW(D2W)) u_sqrt_w (
    .clk_i (clk_i),
    .en_i  (ce),
    .d_i   (hmax4_q),
    .ext_o (ext_w)
  );

  qvc_sqrt #(.DW(D2W)) u_sqrt_h (
    .clk_i (clk_i),
    .en_i  (ce),
    .d_i   (vmax4_q),
    .ext_o (ext_h)
  );

  always_comb begin
    out_item_o.verdict       = vd_q[VDEL-1].verdict;
    out_item_o.extent_width  = ext_w;
    out_item_o.extent_height = ext_h;
    out_item_o.steep         = vd_q[VDEL-1].steep;
  end

endmodule

// ===== rtl/core/qvc_checker.sv =====
module qvc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input qvc_pkg::quad_out_t out_item_o
);
  import qvc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output stall");

  a_steep_usable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.steep |-> out_item_o.verdict == VERDICT_USABLE)
    else $error("steep set on refused quad");

  a_extent_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.extent_width != '0 && out_item_o.extent_height != '0)
    else $error("zero extent");

endmodule

bind quad_validity_classifier_top qvc_checker u_qvc_checker (.*);

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qvc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  quad_in_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  quad_out_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  quad_validity_classifier_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [CFG_DATA_W-1:0] sine_thresh;
  logic [CFG_DATA_W-1:0] steep_thresh;
  quad_out_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned verdict_seen[5];
  int unsigned quads_sent = 0;
  int unsigned cycles = 0;
  int unsigned ready_hold = 0;
  bit calm = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic longint edge_sq(longint x[4], longint y[4], int i, int j);
    longint dx, dy;
    dx = x[j] - x[i];
    dy = y[j] - y[i];
    return dx * dx + dy * dy;
  endfunction

  function automatic logic [EXTENT_W-1:0] extent_of(longint d2);
    longint r, t, n;
    r = 0;
    if (d2 >= longint'(EXT_LIM) * longint'(EXT_LIM)) return EXTENT_MAX;
    for (int b = 22; b >= 0; b--) begin
      t = r + (longint'(1) << b);
      if (t * t <= d2) r = t;
    end
    n = (r + 8) >>> FRAC_BITS;
    if (n < 1) n = 1;
    return n[EXTENT_W-1:0];
  endfunction

  function automatic bit ratio_over(longint p, longint q, logic [CFG_DATA_W-1:0] ratio);
    logic [127:0] mx, mn, rr;
    mx = (p >= q) ? p : q;
    mn = (p >= q) ? q : p;
    rr = 128'(ratio) * 128'(ratio);
    return (128'(65536) * mx) > (rr * mn);
  endfunction

  function automatic quad_out_t classify_quad(quad_in_t q);
    longint x[4], y[4];
    longint t, top, bot, lft, rgt;
    logic [127:0] mag, lhs, rhs;
    int pos, neg, a, b, c;
    quad_out_t r;
    verdict_e v;
    x[0] = q.top_left_x;     y[0] = q.top_left_y;
    x[1] = q.top_right_x;    y[1] = q.top_right_y;
    x[2] = q.bottom_right_x; y[2] = q.bottom_right_y;
    x[3] = q.bottom_left_x;  y[3] = q.bottom_left_y;
    v = VERDICT_USABLE;
    pos = 0;
    neg = 0;
    for (int i = 0; i < 4; i++)
      for (int j = i + 1; j < 4; j++)
        if (edge_sq(x, y, i, j) < ONE_TEXEL_SQ) v = VERDICT_COLLAPSED;
    if (v == VERDICT_USABLE) begin
      for (int i = 0; i < 4 && v == VERDICT_USABLE; i++) begin
        a = i; b = (i + 1) % 4; c = (i + 2) % 4;
        t = (x[b] - x[a]) * (y[c] - y[b]) - (y[b] - y[a]) * (x[c] - x[b]);
        mag = (t < 0) ? -t : t;
        lhs = (mag * mag) << 32;
        rhs = 128'(sine_thresh) * 128'(sine_thresh) * 128'(edge_sq(x, y, a, b))
              * 128'(edge_sq(x, y, b, c));
        if (lhs < rhs) v = VERDICT_COLLINEAR;
        else if (t > 0) pos++;
        else neg++;
      end
      if (v == VERDICT_USABLE) begin
        if (pos != 0 && neg != 0) v = VERDICT_CROSSING;
        else if (pos == 0) v = VERDICT_MIRRORED;
      end
    end
    top = edge_sq(x, y, 0, 1);
    bot = edge_sq(x, y, 3, 2);
    lft = edge_sq(x, y, 0, 3);
    rgt = edge_sq(x, y, 1, 2);
    r.verdict = v;
    r.extent_width = extent_of(top >= bot ? top : bot);
    r.extent_height = extent_of(lft >= rgt ? lft : rgt);
    r.steep = (v == VERDICT_USABLE) &&
              (ratio_over(top, bot, steep_thresh) || ratio_over(lft, rgt, steep_thresh));
    return r;
  endfunction

  function automatic quad_in_t make_quad(int x0, int y0, int x1, int y1,
                                         int x2, int y2, int x3, int y3);
    quad_in_t q;
    q.top_left_x = COORD_WIDTH'(x0);     q.top_left_y = COORD_WIDTH'(y0);
    q.top_right_x = COORD_WIDTH'(x1);    q.top_right_y = COORD_WIDTH'(y1);
    q.bottom_right_x = COORD_WIDTH'(x2); q.bottom_right_y = COORD_WIDTH'(y2);
    q.bottom_left_x = COORD_WIDTH'(x3);  q.bottom_left_y = COORD_WIDTH'(y3);
    return q;
  endfunction

  // request stays valid across back-to-back sends; dropped only for a gap
  task automatic send_quad(input quad_in_t q);
    in_valid_i <= 1'b1;
    in_item_i <= q;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(classify_quad(q));
    quads_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MIN_CORNER_SINE) sine_thresh = val;
    else if (idx == CFG_STEEP_EDGE_RATIO) steep_thresh = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random output stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold = ready_hold - 1;
    end else if (!out_ready_i) begin
      out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      ready_hold = $urandom_range(0, 16);
    end
  end

  always @(posedge clk_i) begin
    quad_out_t exp_r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no pending quad");
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.verdict <= VERDICT_MIRRORED) verdict_seen[exp_r.verdict]++;
        if (out_item_o.verdict !== exp_r.verdict)
          report_mismatch($sformatf("verdict %0d, want %0d",
                                    out_item_o.verdict, exp_r.verdict));
        if (out_item_o.extent_width !== exp_r.extent_width)
          report_mismatch($sformatf("extent_width %0d, want %0d",
                                    out_item_o.extent_width, exp_r.extent_width));
        if (out_item_o.extent_height !== exp_r.extent_height)
          report_mismatch($sformatf("extent_height %0d, want %0d",
                                    out_item_o.extent_height, exp_r.extent_height));
        if (out_item_o.steep !== exp_r.steep)
          report_mismatch($sformatf("steep %0b, want %0b", out_item_o.steep, exp_r.steep));
      end
    end
  end

  task automatic test_directed();
    send_quad(make_quad(0, 0, 160, 0, 160, 160, 0, 160));
    send_quad(make_quad(0, 0, 8, 0, 160, 160, 0, 160));
    send_quad(make_quad(0, 0, 160, 0, 320, 0, 0, 160));
    send_quad(make_quad(0, 0, 160, 0, 0, 160, 160, 160));
    send_quad(make_quad(0, 0, 0, 160, 160, 160, 160, 0));
    send_quad(make_quad(0, 0, 1600, 0, 1000, 160, 600, 160));
    send_quad(make_quad(0, 0, 160, 0, 160, 1600, 0, 1600));
    send_quad(make_quad(0, 0, 160, 0, 160, 1700, 0, 400));
    send_quad(make_quad(-524288, -524288, 524287, -524288, 524287, 524287,
                        -524288, 524287));
    send_quad(make_quad(-524288, 524287, 524287, -524288, 524287, 524287,
                        -524288, -524288));
    send_quad(make_quad(524287, 524287, 524287, 524287, 524287, 524287,
                        524287, 524287));
    send_quad(make_quad(-524288, -524288, -524288, -524288, -524288, -524288,
                        -524288, -524288));
    send_quad(make_quad(0, 0, 16, 0, 16, 16, 0, 16));
    send_quad(make_quad(0, 0, 15, 0, 15, 15, 0, 15));
    send_quad(make_quad(0, 0, 24, 0, 24, 24, 0, 24));
    send_quad(make_quad(0, 0, 1600, 0, 1600, 40, 0, 20));
    wait_idle();
  endtask

  task automatic send_random(input int count);
    quad_in_t q;
    int cx, cy, w, h, kind, sz;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        q = {$urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
        sz = ($urandom_range(0, 7) == 0) ? 200000 : 3000;
        cx = $signed($urandom_range(0, 400000)) - 200000;
        cy = $signed($urandom_range(0, 400000)) - 200000;
        w = $urandom_range(1, sz);
        h = $urandom_range(1, sz);
        q = make_quad(cx - w + $signed($urandom_range(0, w)) - w / 2,
                      cy - h + $signed($urandom_range(0, 8)) - 4,
                      cx + w + $signed($urandom_range(0, w)) - w / 2,
                      cy - h + $signed($urandom_range(0, h)) - h / 2,
                      cx + w + $signed($urandom_range(0, 8)) - 4,
                      cy + h + $signed($urandom_range(0, h)) - h / 2,
                      cx - w + $signed($urandom_range(0, w)) - w / 2,
                      cy + h + $signed($urandom_range(0, 8)) - 4);
        if (kind == 1) q = make_quad(q.top_left_x, q.top_left_y, q.top_right_x,
                                     q.top_right_y, q.bottom_left_x, q.bottom_left_y,
                                     q.bottom_right_x, q.bottom_right_y);
        else if (kind == 2) q = make_quad(q.top_left_x, q.top_left_y, q.bottom_left_x,
                                          q.bottom_left_y, q.bottom_right_x,
                                          q.bottom_right_y, q.top_right_x, q.top_right_y);
        else if (kind == 3) q.bottom_right_x = COORD_WIDTH'(int'(q.top_right_x) +
                                                            $signed($urandom_range(0, 2)));
      end
      send_quad(q);
    end
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_MIN_CORNER_SINE, '0);
    write_reg(CFG_STEEP_EDGE_RATIO, '0);
    send_quad(make_quad(0, 0, 160, 0, 320, 0, 0, 160));
    send_random(150);
    wait_idle();
    write_reg(CFG_MIN_CORNER_SINE, '1);
    write_reg(CFG_STEEP_EDGE_RATIO, '1);
    send_random(150);
    wait_idle();
    write_reg(CFG_MIN_CORNER_SINE, 16'd1);
    write_reg(CFG_STEEP_EDGE_RATIO, 16'd256);
    send_random(150);
    wait_idle();
  endtask

  task automatic test_unknown_index();
    write_reg(CFG_IDX_W'(2), '1);
    write_reg(CFG_IDX_W'(3), '0);
    send_random(50);
    wait_idle();
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 2; k++) begin
      write_reg(CFG_MIN_CORNER_SINE, CFG_DATA_W'($urandom_range(0, 20000)));
      write_reg(CFG_STEEP_EDGE_RATIO, CFG_DATA_W'($urandom_range(256, 1200)));
      send_random(100);
      wait_idle();
    end
    calm = 1'b1;
    send_random(150);
    wait_idle();
  endtask

  initial begin
    sine_thresh = MIN_CORNER_SINE_RST;
    steep_thresh = STEEP_EDGE_RATIO_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_unknown_index();
    test_random_settings();
    $display("%0d quads: usable %0d, collapsed %0d, collinear %0d, crossing %0d,",
             quads_sent, verdict_seen[0], verdict_seen[1], verdict_seen[2],
             verdict_seen[3]);
    $display("  mirrored %0d, over several threshold settings; %0d mismatches",
             verdict_seen[4], mismatches);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/qvc_pkg.sv
rtl/core/qvc_mul.sv
rtl/core/qvc_sqrt.sv
rtl/core/quad_validity_classifier_top.sv
rtl/core/qvc_checker.sv
verif/testbench.sv
